// ----- src/u8pv_pkg.sv -----
package u8pv_pkg;

    localparam int unsigned CountWidth = 17;
    localparam int unsigned LimitWidth = 16;
    localparam int unsigned CodeWidth  = 21;

    localparam logic [LimitWidth-1:0] MaxPathReset = 16'd1024;

    localparam logic [7:0] ByteSlash     = 8'h2f;
    localparam logic [7:0] ByteDot       = 8'h2e;
    localparam logic [7:0] ByteBackslash = 8'h5c;
    localparam logic [7:0] ByteDel       = 8'h7f;
    localparam logic [7:0] ByteSpace     = 8'h20;

    localparam logic [CodeWidth-1:0] CodeMin2    = 21'h000080;
    localparam logic [CodeWidth-1:0] CodeMin3    = 21'h000800;
    localparam logic [CodeWidth-1:0] CodeMin4    = 21'h010000;
    localparam logic [CodeWidth-1:0] CodeMax     = 21'h10ffff;
    localparam logic [CodeWidth-1:0] SurrogateLo = 21'h00d800;
    localparam logic [CodeWidth-1:0] SurrogateHi = 21'h00dfff;

    localparam logic [CountWidth-1:0] CountSaturate = 17'h10000;

    // number of continuation bytes that follow a lead byte
    localparam logic [1:0] SeqNone  = 2'd0;
    localparam logic [1:0] SeqTwo   = 2'd1;
    localparam logic [1:0] SeqThree = 2'd2;
    localparam logic [1:0] SeqFour  = 2'd3;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       is_last;
        logic       is_empty;
    } item_t;

    typedef struct packed {
        logic                  path_valid;
        logic [CountWidth-1:0] path_length;
    } result_t;

endpackage

// ----- src/u8pv_check.sv -----
module u8pv_check
    import u8pv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 item,
    input  logic                  advance,
    input  logic [LimitWidth-1:0] max_path_bytes,
    output logic                  has_result,
    output result_t               result
);

    logic [CountWidth-1:0] byte_count_reg, byte_count_next;
    logic [1:0]            seg_len_reg, seg_len_next;
    logic                  seg_dots_reg, seg_dots_next;
    logic [1:0]            utf_rem_reg, utf_rem_next;
    logic [1:0]            utf_len_reg, utf_len_next;
    logic [CodeWidth-1:0]  code_reg, code_next;
    logic                  failed_reg, failed_next;

    logic [7:0]            b;
    logic [CountWidth-1:0] cnt;
    logic [1:0]            seg_len;
    logic                  seg_dots;
    logic [1:0]            urem;
    logic [1:0]            ulen;
    logic [CodeWidth-1:0]  acc;
    logic                  fail;
    logic                  ok;

    assign b          = item.path_byte;
    assign has_result = item.is_last || item.is_empty;

    always_comb
    begin
        cnt      = byte_count_reg;
        seg_len  = seg_len_reg;
        seg_dots = seg_dots_reg;
        urem     = utf_rem_reg;
        ulen     = utf_len_reg;
        acc      = code_reg;
        fail     = failed_reg;

        if (cnt != CountSaturate)
        begin
            cnt = cnt + 17'd1;
        end

        if (b == ByteBackslash || b < ByteSpace || b == ByteDel)
        begin
            fail = 1'b1;
        end

        if (b == ByteSlash)
        begin
            if (seg_len == 2'd0 || (seg_dots && seg_len != 2'd3))
            begin
                fail = 1'b1;
            end
            seg_len  = 2'd0;
            seg_dots = 1'b1;
        end
        else
        begin
            if (seg_len != 2'd3)
            begin
                seg_len = seg_len + 2'd1;
            end
            if (b != ByteDot)
            begin
                seg_dots = 1'b0;
            end
        end

        if (urem == SeqNone)
        begin
            if (b[7])
            begin
                if (b[7:5] == 3'b110)
                begin
                    ulen = SeqTwo;
                    acc  = {16'd0, b[4:0]};
                    urem = SeqTwo;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    ulen = SeqThree;
                    acc  = {17'd0, b[3:0]};
                    urem = SeqThree;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    ulen = SeqFour;
                    acc  = {18'd0, b[2:0]};
                    urem = SeqFour;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // broken sequence: restart decoding at the next byte
            fail = 1'b1;
            urem = SeqNone;
            ulen = SeqNone;
            acc  = '0;
        end
        else
        begin
            acc  = {acc[CodeWidth-7:0], b[5:0]};
            urem = urem - 2'd1;
            if (urem == SeqNone)
            begin
                if ((ulen == SeqTwo && acc < CodeMin2) ||
                    (ulen == SeqThree && acc < CodeMin3) ||
                    (ulen == SeqFour && acc < CodeMin4) ||
                    acc > CodeMax ||
                    (acc >= SurrogateLo && acc <= SurrogateHi))
                begin
                    fail = 1'b1;
                end
                ulen = SeqNone;
                acc  = '0;
            end
        end

        ok = !fail;
        if (cnt > {1'b0, max_path_bytes} || cnt[CountWidth-1])
        begin
            ok = 1'b0;
        end
        if (seg_len == 2'd0 || (seg_dots && seg_len != 2'd3))
        begin
            ok = 1'b0;
        end
        if (urem != SeqNone)
        begin
            ok = 1'b0;
        end

        if (item.is_empty)
        begin
            result.path_valid  = 1'b0;
            result.path_length = '0;
        end
        else
        begin
            result.path_valid  = ok;
            result.path_length = cnt;
        end

        if (has_result)
        begin
            byte_count_next = '0;
            seg_len_next    = 2'd0;
            seg_dots_next   = 1'b1;
            utf_rem_next    = SeqNone;
            utf_len_next    = SeqNone;
            code_next       = '0;
            failed_next     = 1'b0;
        end
        else
        begin
            byte_count_next = cnt;
            seg_len_next    = seg_len;
            seg_dots_next   = seg_dots;
            utf_rem_next    = urem;
            utf_len_next    = ulen;
            code_next       = acc;
            failed_next     = fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            seg_len_reg    <= 2'd0;
            seg_dots_reg   <= 1'b1;
            utf_rem_reg    <= SeqNone;
            utf_len_reg    <= SeqNone;
            code_reg       <= '0;
            failed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            byte_count_reg <= byte_count_next;
            seg_len_reg    <= seg_len_next;
            seg_dots_reg   <= seg_dots_next;
            utf_rem_reg    <= utf_rem_next;
            utf_len_reg    <= utf_len_next;
            code_reg       <= code_next;
            failed_reg     <= failed_next;
        end
    end

endmodule

// ----- src/u8pv_out_reg.sv -----
module u8pv_out_reg
    import u8pv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- src/utf8_path_validator.sv -----
// A byte's verdict reaches the outputs through the input register, then the
// result register. Throughput: one byte per cycle; the input stalls only
// while out_stall holds a verdict in the result register and the byte in
// the input register makes one.
// Reset (rst_n, async, active low) clears all path state and sets the
// length limit to 1024.
module utf8_path_validator
    import u8pv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LimitWidth-1:0] cfg_max_path_bytes,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            path_byte,
    input  logic                  is_last,
    input  logic                  is_empty,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  path_valid,
    output logic [CountWidth-1:0] path_length
);

    logic [LimitWidth-1:0] max_path_reg;
    logic                  stage_valid_reg, stage_valid_next;
    item_t                 stage_item_reg;
    logic                  has_result;
    logic                  advance;
    logic                  fire;
    result_t               result;
    result_t               out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_path_reg <= MaxPathReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_path_reg <= cfg_max_path_bytes;
        end
    end

    // the staged byte moves on unless it makes a verdict that cannot be stored
    assign advance  = !has_result || !out_valid || !out_stall;
    assign fire     = stage_valid_reg && advance;
    assign in_stall = stage_valid_reg && !advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (!in_stall)
        begin
            stage_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_item_reg <= '{path_byte: path_byte, is_last: is_last, is_empty: is_empty};
        end
    end

    u8pv_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (stage_item_reg),
        .advance        (fire),
        .max_path_bytes (max_path_reg),
        .has_result     (has_result),
        .result         (result)
    );

    u8pv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && has_result),
        .load_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign path_valid  = out_data.path_valid;
    assign path_length = out_data.path_length;

endmodule
